@@ rtl/pqpi_pkg.sv @@
// Shared types, sizes and helpers for the point queue with positional insert.
// Used by pqpi_cell and point_queue_with_positional_insert_core; no dependencies.
package pqpi_pkg;

    localparam int Depth      = 16;
    localparam int CoordWidth = 16;
    localparam int FieldWidth = 16;
    localparam int PosWidth   = 5;
    localparam int CountWidth = $clog2(Depth + 1);
    localparam int CmpWidth   = (CountWidth > PosWidth) ? CountWidth : PosWidth;

    typedef logic [CoordWidth-1:0] coord_t;
    typedef logic [CmpWidth-1:0]   cmp_t;
    typedef logic [CountWidth-1:0] count_t;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_SEARCH = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_mode_t;

    typedef struct packed {
        action_t                      action;
        logic signed [FieldWidth-1:0] coord_x;
        logic signed [FieldWidth-1:0] coord_y;
        logic [PosWidth-1:0]          position;
    } req_t;

    typedef struct packed {
        status_t                      status;
        logic signed [FieldWidth-1:0] removed_x;
        logic signed [FieldWidth-1:0] removed_y;
        logic                         found;
        logic [PosWidth-1:0]          entry_count;
    } rsp_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        cell_mode_t mode;
        cmp_t       pos;
        cmp_t       count;
        coord_t     key_x;
        coord_t     key_y;
    } cell_ctl_t;

    function automatic coord_t field_to_coord(input logic [FieldWidth-1:0] v);
        return CoordWidth'(v);
    endfunction

    // Sign-extend from the stored width, then fit to the field width.
    function automatic logic signed [FieldWidth-1:0] coord_to_field(input coord_t v);
        logic signed [CoordWidth-1:0] s;
        s = signed'(v);
        return FieldWidth'(s);
    endfunction

endpackage

@@ rtl/pqpi_cell.sv @@
// One slot of the entry row: holds a coordinate pair, shifts toward or away
// from the head on insert/remove and flags a key match. Uses pqpi_pkg.
module pqpi_cell (
    input  logic               clk,
    input  pqpi_pkg::cell_ctl_t ctl,
    input  pqpi_pkg::cmp_t     idx,
    input  pqpi_pkg::coord_t   prev_x,
    input  pqpi_pkg::coord_t   prev_y,
    input  pqpi_pkg::coord_t   next_x,
    input  pqpi_pkg::coord_t   next_y,
    output pqpi_pkg::coord_t   x,
    output pqpi_pkg::coord_t   y,
    output logic               hit
);

    pqpi_pkg::coord_t x_reg;
    pqpi_pkg::coord_t y_reg;
    pqpi_pkg::coord_t x_next;
    pqpi_pkg::coord_t y_next;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        unique case (ctl.mode)
            pqpi_pkg::CELL_INSERT:
            begin
                if (idx == ctl.pos)
                begin
                    x_next = ctl.key_x;
                    y_next = ctl.key_y;
                end
                else if (idx > ctl.pos)
                begin
                    // move back by one slot
                    x_next = prev_x;
                    y_next = prev_y;
                end
            end
            pqpi_pkg::CELL_REMOVE:
            begin
                x_next = next_x;
                y_next = next_y;
            end
            default:
            begin
                x_next = x_reg;
                y_next = y_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign x   = x_reg;
    assign y   = y_reg;
    assign hit = (idx < ctl.count) && (x_reg == ctl.key_x) && (y_reg == ctl.key_y);

endmodule

@@ rtl/point_queue_with_positional_insert_core.sv @@
// Top level of the point queue with positional insert: a row of pqpi_cell
// slots, the entry counter and the response register. Uses pqpi_pkg.
//
// Usage:
//   req channel (req_valid, req_stall, req) carries one operation per beat:
//   append, insert at position, remove head, or search for an (x, y) pair.
//   rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one beat per
//   request with status, removed head coordinates, found flag and the
//   entry count after the operation.
//   The response is registered and is valid in the cycle after its request is taken.
//   Throughput is one request per cycle while no response is held by rsp_stall; every slot
//   shifts and compares in parallel in the cycle a request is taken, so the row of cells and
//   the match-reduction across it set the pace.
//   While a response is held by rsp_stall, req_stall is high and no new
//   request is taken; the held response does not change.
//   Reset clears the entry count and the response valid; slot contents are
//   not cleared and are never read beyond the entry count.
module point_queue_with_positional_insert_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  pqpi_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output pqpi_pkg::rsp_t rsp
);

    pqpi_pkg::count_t    count_reg;
    pqpi_pkg::count_t    count_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    pqpi_pkg::rsp_t      rsp_reg;
    pqpi_pkg::rsp_t      rsp_next;
    pqpi_pkg::cell_ctl_t ctl;
    pqpi_pkg::coord_t    cell_x [pqpi_pkg::Depth];
    pqpi_pkg::coord_t    cell_y [pqpi_pkg::Depth];
    logic [pqpi_pkg::Depth-1:0] hits;
    logic                accept;
    pqpi_pkg::cmp_t      count_cmp;
    pqpi_pkg::cmp_t      ins_pos;
    logic                full;
    logic                do_insert;
    logic                do_remove;

    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;
    assign count_cmp = pqpi_pkg::CmpWidth'(count_reg);
    assign full      = (count_cmp == pqpi_pkg::CmpWidth'(pqpi_pkg::Depth));
    assign ins_pos   = (req.action == pqpi_pkg::ACT_APPEND)
                       ? count_cmp : pqpi_pkg::CmpWidth'(req.position);

    assign do_insert = accept
                       & ((req.action == pqpi_pkg::ACT_APPEND)
                          | (req.action == pqpi_pkg::ACT_INSERT))
                       & ~full & (ins_pos <= count_cmp);
    assign do_remove = accept & (req.action == pqpi_pkg::ACT_REMOVE)
                       & (count_reg != '0);

    generate
        for (genvar i = 0; i < pqpi_pkg::Depth; i++)
        begin : g_cell
            pqpi_pkg::coord_t px, py, nx, ny;
            if (i == 0)
            begin : g_head
                assign px = ctl.key_x;
                assign py = ctl.key_y;
            end
            else
            begin : g_body
                assign px = cell_x[i-1];
                assign py = cell_y[i-1];
            end
            if (i == pqpi_pkg::Depth - 1)
            begin : g_last
                assign nx = cell_x[i];
                assign ny = cell_y[i];
            end
            else
            begin : g_inner
                assign nx = cell_x[i+1];
                assign ny = cell_y[i+1];
            end

            pqpi_cell u_cell (
                .clk    (clk),
                .ctl    (ctl),
                .idx    (pqpi_pkg::CmpWidth'(i)),
                .prev_x (px),
                .prev_y (py),
                .next_x (nx),
                .next_y (ny),
                .x      (cell_x[i]),
                .y      (cell_y[i]),
                .hit    (hits[i])
            );
        end
    endgenerate

    // Row control; kept apart from the response logic that reads the hits.
    always_comb
    begin
        ctl.mode  = pqpi_pkg::CELL_HOLD;
        if (do_insert)
            ctl.mode = pqpi_pkg::CELL_INSERT;
        else if (do_remove)
            ctl.mode = pqpi_pkg::CELL_REMOVE;
        ctl.pos   = ins_pos;
        ctl.count = count_cmp;
        ctl.key_x = pqpi_pkg::field_to_coord(req.coord_x);
        ctl.key_y = pqpi_pkg::field_to_coord(req.coord_y);
    end

    always_comb
    begin
        count_next           = count_reg;
        rsp_next             = rsp_reg;
        rsp_valid_next       = rsp_valid_reg & rsp_stall;

        if (accept)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.status      = pqpi_pkg::ST_OK;
            rsp_next.removed_x   = '0;
            rsp_next.removed_y   = '0;
            rsp_next.found       = 1'b0;
            unique case (req.action)
                pqpi_pkg::ACT_APPEND, pqpi_pkg::ACT_INSERT:
                begin
                    if (full)
                        rsp_next.status = pqpi_pkg::ST_FULL;
                    else if (ins_pos > count_cmp)
                        rsp_next.status = pqpi_pkg::ST_RANGE;
                    else
                        count_next = count_reg + pqpi_pkg::count_t'(1);
                end
                pqpi_pkg::ACT_REMOVE:
                begin
                    if (count_reg == '0)
                        rsp_next.status = pqpi_pkg::ST_EMPTY;
                    else
                    begin
                        rsp_next.removed_x = pqpi_pkg::coord_to_field(cell_x[0]);
                        rsp_next.removed_y = pqpi_pkg::coord_to_field(cell_y[0]);
                        count_next         = count_reg - pqpi_pkg::count_t'(1);
                    end
                end
                pqpi_pkg::ACT_SEARCH:
                begin
                    rsp_next.found = |hits;
                end
                default:
                begin
                    rsp_next.status = pqpi_pkg::ST_OK;
                end
            endcase
            rsp_next.entry_count = pqpi_pkg::PosWidth'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // hold the response payload while stalled
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ verif/tb_point_queue_with_positional_insert_core.sv @@
// Self-checking testbench for point_queue_with_positional_insert_core: directed and random
// operations with random request gaps and response stalls, checked against a shadow point list.
// Depends on pqpi_pkg and the core RTL.

class point_queue_scoreboard;

    typedef struct packed {
        pqpi_pkg::coord_t x;
        pqpi_pkg::coord_t y;
    } point_t;

    point_t           stored_points[$];
    pqpi_pkg::rsp_t   pending_replies[$];
    int               errors;

    function new();
        errors = 0;
    endfunction

    function int pending();
        return pending_replies.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its reply.
    function void note_request(pqpi_pkg::req_t r);
        pqpi_pkg::rsp_t e;
        point_t         p;
        int             pos;
        int             n;
        e = '0;
        e.status = pqpi_pkg::ST_OK;
        p.x = pqpi_pkg::coord_t'(r.coord_x);
        p.y = pqpi_pkg::coord_t'(r.coord_y);
        n = stored_points.size();
        case (r.action)
            pqpi_pkg::ACT_APPEND, pqpi_pkg::ACT_INSERT:
            begin
                pos = (r.action == pqpi_pkg::ACT_APPEND) ? n : int'(r.position);
                if (n >= pqpi_pkg::Depth)
                    e.status = pqpi_pkg::ST_FULL;
                else if (pos > n)
                    e.status = pqpi_pkg::ST_RANGE;
                else if (pos == n)
                    stored_points.push_back(p);
                else
                    stored_points.insert(pos, p);
            end
            pqpi_pkg::ACT_REMOVE:
            begin
                if (n == 0)
                    e.status = pqpi_pkg::ST_EMPTY;
                else
                begin
                    p = stored_points.pop_front();
                    e.removed_x = pqpi_pkg::FieldWidth'(signed'(p.x));
                    e.removed_y = pqpi_pkg::FieldWidth'(signed'(p.y));
                end
            end
            default:
            begin
                foreach (stored_points[i])
                begin
                    if (stored_points[i].x == p.x && stored_points[i].y == p.y)
                        e.found = 1'b1;
                end
            end
        endcase
        e.entry_count = pqpi_pkg::PosWidth'(stored_points.size());
        pending_replies.push_back(e);
    endfunction

    function void compare_field(string name, logic signed [31:0] exp_v,
                                logic signed [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_response(pqpi_pkg::rsp_t a);
        pqpi_pkg::rsp_t e;
        if (pending_replies.size() == 0)
        begin
            $display("%0t: response beat with none expected, actual status %0d count %0d",
                     $time, a.status, a.entry_count);
            errors++;
            return;
        end
        e = pending_replies.pop_front();
        compare_field("status", 32'(e.status), 32'(a.status));
        compare_field("removed_x", 32'(e.removed_x), 32'(a.removed_x));
        compare_field("removed_y", 32'(e.removed_y), 32'(a.removed_y));
        compare_field("found", 32'(e.found), 32'(a.found));
        compare_field("entry_count", 32'(e.entry_count), 32'(a.entry_count));
    endfunction

endclass

module tb_point_queue_with_positional_insert_core;

    localparam int NumRandom     = 500;
    localparam int PhaseLen      = 40;
    localparam int QuietTail     = 60;
    localparam int PressureAt    = 200;
    localparam int HoldOffCycles = 80;
    localparam int WatchdogLimit = 2000;
    localparam int PoolSize      = 8;

    typedef enum int {
        MIX_FILL,
        MIX_EVEN,
        MIX_DRAIN
    } op_mix_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    pqpi_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    pqpi_pkg::rsp_t rsp;

    point_queue_scoreboard sb;

    logic signed [15:0] pool_x [PoolSize];
    logic signed [15:0] pool_y [PoolSize];

    bit quiet;
    bit hold_off_req;
    int idle_cycles;

    point_queue_with_positional_insert_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic pqpi_pkg::req_t make_req(pqpi_pkg::action_t a,
                                                logic signed [15:0] x,
                                                logic signed [15:0] y, int p);
        pqpi_pkg::req_t r;
        r.action   = a;
        r.coord_x  = x;
        r.coord_y  = y;
        r.position = pqpi_pkg::PosWidth'(p);
        return r;
    endfunction

    // Coordinates come half from a small pool so searches hit and duplicates occur.
    function automatic pqpi_pkg::req_t random_request(op_mix_t mix);
        pqpi_pkg::req_t    r;
        int                roll;
        int                k;
        pqpi_pkg::action_t a;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  a = (roll < 35) ? pqpi_pkg::ACT_APPEND :
                           (roll < 70) ? pqpi_pkg::ACT_INSERT :
                           (roll < 80) ? pqpi_pkg::ACT_REMOVE : pqpi_pkg::ACT_SEARCH;
            MIX_DRAIN: a = (roll < 10) ? pqpi_pkg::ACT_APPEND :
                           (roll < 20) ? pqpi_pkg::ACT_INSERT :
                           (roll < 80) ? pqpi_pkg::ACT_REMOVE : pqpi_pkg::ACT_SEARCH;
            default:   a = pqpi_pkg::action_t'(roll % 4);
        endcase
        k = $urandom_range(0, PoolSize - 1);
        r.action = a;
        if ($urandom_range(0, 1) == 0)
        begin
            r.coord_x = pool_x[k];
            r.coord_y = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pool_y[k];
        end
        else
        begin
            r.coord_x = 16'($urandom);
            r.coord_y = 16'($urandom);
        end
        if ($urandom_range(0, 99) < 85)
            r.position = pqpi_pkg::PosWidth'($urandom_range(0, pqpi_pkg::Depth));
        else
            r.position = pqpi_pkg::PosWidth'($urandom_range(0, 31));
        return r;
    endfunction

    // Hold the beat until the block takes it; valid stays up for the caller.
    task automatic send_beat(input pqpi_pkg::req_t r);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic pause(input int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Check the response first: a beat accepted at this edge answers an older request.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
        if (rst_n && req_valid && !req_stall)
            sb.note_request(req);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none at the end.
    initial
    begin
        bit stalled;
        bit held;
        held = 1'b0;
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HoldOffCycles) @(posedge clk);
            end
            else if (quiet)
            begin
                rsp_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                stalled = ($urandom_range(0, 2) == 0);
                rsp_stall <= stalled;
                repeat (stalled ? $urandom_range(1, 10) : $urandom_range(1, 30))
                    @(posedge clk);
            end
        end
    end

    initial
    begin
        logic signed [15:0] last_x;
        logic signed [15:0] last_y;
        op_mix_t            mix;
        bit                 gaps_on;
        int                 no_gap_until;

        sb           = new();
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rst_n        = 1'b0;

        pool_x[0] = 16'sh8000; pool_y[0] = 16'sh8000;
        pool_x[1] = 16'sh7FFF; pool_y[1] = 16'sh7FFF;
        pool_x[2] = 16'sh0000; pool_y[2] = 16'sh0000;
        pool_x[3] = -16'sd1;   pool_y[3] = 16'sd1;
        for (int i = 4; i < PoolSize; i++)
        begin
            pool_x[i] = 16'($urandom);
            pool_y[i] = 16'($urandom);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store: remove, search and out-of-range insert.
        send_beat(make_req(pqpi_pkg::ACT_REMOVE, 16'sh1234, 16'sh4321, 0));
        send_beat(make_req(pqpi_pkg::ACT_SEARCH, 16'sh0000, 16'sh0000, 0));
        send_beat(make_req(pqpi_pkg::ACT_INSERT, 16'sh0011, 16'sh0022, 1));
        // Insert at head of an empty store, then append behind it.
        send_beat(make_req(pqpi_pkg::ACT_INSERT, 16'sh8000, 16'sh7FFF, 0));
        send_beat(make_req(pqpi_pkg::ACT_APPEND, 16'sh7FFF, 16'sh8000, 0));
        send_beat(make_req(pqpi_pkg::ACT_INSERT, 16'sh0000, 16'sh0000, 1));
        send_beat(make_req(pqpi_pkg::ACT_INSERT, -16'sd1, -16'sd1, 31));
        send_beat(make_req(pqpi_pkg::ACT_INSERT, -16'sd1, -16'sd1, 3));
        send_beat(make_req(pqpi_pkg::ACT_SEARCH, 16'sh0000, 16'sh0000, 0));
        // x matches an entry, y does not.
        send_beat(make_req(pqpi_pkg::ACT_SEARCH, 16'sh7FFF, 16'sh7FFF, 0));
        send_beat(make_req(pqpi_pkg::ACT_REMOVE, 16'sh0000, 16'sh0000, 0));
        // Fill to the top, mixing appends and head inserts.
        last_x = '0;
        last_y = '0;
        for (int i = 0; i < pqpi_pkg::Depth - 3; i++)
        begin
            last_x = 16'sh5555 ^ 16'(i);
            last_y = 16'shAAAA + 16'(i);
            if (i % 2 == 0)
                send_beat(make_req(pqpi_pkg::ACT_APPEND, last_x, last_y, 0));
            else
                send_beat(make_req(pqpi_pkg::ACT_INSERT, last_y, last_x, 0));
        end
        // Full store: full wins over a bad position.
        send_beat(make_req(pqpi_pkg::ACT_APPEND, 16'sh0101, 16'sh0202, 0));
        send_beat(make_req(pqpi_pkg::ACT_INSERT, 16'sh0303, 16'sh0404, 31));
        send_beat(make_req(pqpi_pkg::ACT_SEARCH, last_x, last_y, 0));

        no_gap_until = -1;
        for (int n = 0; n < NumRandom; n++)
        begin
            case ((n / PhaseLen) % 3)
                0:       mix = MIX_FILL;
                1:       mix = MIX_EVEN;
                default: mix = MIX_DRAIN;
            endcase
            gaps_on = ((n / PhaseLen) % 4 != 3) && (n > no_gap_until);
            if (n == PressureAt)
            begin
                hold_off_req = 1'b1;
                no_gap_until = n + 30;
                gaps_on      = 1'b0;
            end
            if (n == NumRandom - QuietTail)
                quiet = 1'b1;
            if (quiet)
                gaps_on = 1'b0;
            if (gaps_on && $urandom_range(0, 3) == 0)
                pause($urandom_range(1, 10));
            send_beat(random_request(mix));
        end
        req_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
